/* rtl/core/rlh_pkg.sv */
// rlh_pkg: shared constants and types for the recurrence line histogram core.
// No dependencies; imported by rlh_merge, rlh_hist and the top level.
package rlh_pkg;

   localparam int FIELD_LANES = 4;    // vector components carried by one item
   localparam int BIN_IDX_W   = 10;   // width of the bin index field
   localparam int OPC_W       = 2;
   localparam int NORM_W      = 2;
   localparam int THR_W       = 18;
   localparam int LIMIT_W     = 2 * THR_W;
   localparam int DIMS_W      = 3;
   localparam int CNT_W       = 32;

   // distance norms
   localparam logic [NORM_W-1:0] NORM_EUCLID = 2'd0;
   localparam logic [NORM_W-1:0] NORM_MAX    = 2'd1;
   localparam logic [NORM_W-1:0] NORM_SUM    = 2'd2;

   // request opcodes
   localparam logic [OPC_W-1:0] OP_COMPARE = 2'd0;
   localparam logic [OPC_W-1:0] OP_READ    = 2'd1;
   localparam logic [OPC_W-1:0] OP_CLEAR   = 2'd2;
   localparam logic [OPC_W-1:0] OP_NOP     = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_NORM      = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_DIMS      = 2'd2;

   // one read-modify-write on a histogram bin
   typedef struct packed {
      logic valid;   // issue the read this cycle
      logic kind;    // 0 diagonal, 1 vertical
      logic zero;    // write back zero instead of count + 1
   } hist_cmd_type;

endpackage

/* rtl/core/recurrence_line_histogram_core.sv */
// recurrence_line_histogram_core: top level of the recurrence line histogram.
// Depends on rlh_pkg, rlh_lane, rlh_merge and rlh_hist.
//
// Usage:
//  - Request channel: an item transfers at a rising edge with start high and
//    busy low. opcode 0 compares the vector pair x/y, 1 reads and clears a
//    histogram bin, 2 clears run lengths and totals, 3 does nothing.
//  - Response channel: rsp_valid is high for exactly one cycle per item; the
//    transfer happens at the edge that ends that cycle. The receiver cannot
//    stall, so there is no back-pressure path.
//  - Sequence: after the request edge the item walks through the states DIFF,
//    SQUARE, MERGE, COMPARE and UPDATE, and the response shows in ST_RESP.
//    One item is in flight at a time; busy drops during the response cycle,
//    so the next request may transfer at the edge that ends it. The walk goes
//    through lane difference, square, merge, compare, bin read and bin write.
//  - Config: csr_we writes csr_wdata into register csr_index (0 norm mode,
//    1 threshold, 2 embedding dims) at the clock edge. The user writes only
//    while idle; the block itself does not enforce this.
//  - Reset: synchronous. Runs, totals and config go to their defaults at once;
//    the histogram memory is then swept to zero, one entry a cycle, and busy
//    stays high through the sweep. Config writes are taken meanwhile.
module recurrence_line_histogram_core #(
   parameter int HIST_BINS   = 1024,
   parameter int LANES       = 4,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               start,
   output logic                               busy,
   input  logic [rlh_pkg::OPC_W-1:0]          req_opcode,
   input  logic                               req_line_kind,
   input  logic                               req_last_in_line,
   input  logic [rlh_pkg::BIN_IDX_W-1:0]      req_bin_index,
   input  logic signed [SAMPLE_BITS-1:0]      req_x0,
   input  logic signed [SAMPLE_BITS-1:0]      req_x1,
   input  logic signed [SAMPLE_BITS-1:0]      req_x2,
   input  logic signed [SAMPLE_BITS-1:0]      req_x3,
   input  logic signed [SAMPLE_BITS-1:0]      req_y0,
   input  logic signed [SAMPLE_BITS-1:0]      req_y1,
   input  logic signed [SAMPLE_BITS-1:0]      req_y2,
   input  logic signed [SAMPLE_BITS-1:0]      req_y3,
   // response
   output logic                               rsp_valid,
   output logic                               rsp_recurrent,
   output logic [rlh_pkg::CNT_W-1:0]          rsp_bin_count,
   output logic [rlh_pkg::CNT_W-1:0]          rsp_recurrence_total,
   output logic [rlh_pkg::CNT_W-1:0]          rsp_point_total,
   // configuration
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [rlh_pkg::THR_W-1:0]          csr_wdata
);
   import rlh_pkg::*;

   localparam int ACT_LANES = LANES < FIELD_LANES ? LANES : FIELD_LANES;
   localparam int BIN_W     = $clog2(HIST_BINS);
   localparam int BEXT_W    = (BIN_W > BIN_IDX_W ? BIN_W : BIN_IDX_W) + 1;
   localparam logic [BIN_W-1:0] RUN_MAX = BIN_W'(HIST_BINS - 1);

   typedef enum logic [7:0] {
      ST_CLEAR   = 8'b0000_0001,  // memory sweep after reset
      ST_IDLE    = 8'b0000_0010,
      ST_DIFF    = 8'b0000_0100,  // lanes form |x - y|
      ST_SQUARE  = 8'b0000_1000,  // lanes square
      ST_MERGE   = 8'b0001_0000,  // lanes combined into the distance
      ST_COMPARE = 8'b0010_0000,  // distance against the limit
      ST_UPDATE  = 8'b0100_0000,  // runs, totals, bin read issued
      ST_RESP    = 8'b1000_0000   // result shown, bin written back
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [NORM_W-1:0]  norm_ff;
   logic [THR_W-1:0]   thr_ff;
   logic [LIMIT_W-1:0] thr_sq_ff;
   logic [DIMS_W-1:0]  dims_ff;
   logic [LIMIT_W-1:0] limit;

   // captured request control
   logic [OPC_W-1:0]     op_ff;
   logic                 kind_ff;
   logic                 last_ff;
   logic [BIN_IDX_W-1:0] bin_ff;

   // run lengths and totals
   logic [BIN_W-1:0] diag_run_ff, vert_run_ff;
   logic [CNT_W-1:0] rec_total_ff, point_total_ff;
   logic             rsp_rec_ff;
   logic             bin_sel_ff;

   logic accept;
   logic recurrent;
   logic clear_busy;

   logic signed [SAMPLE_BITS-1:0] xs [FIELD_LANES];
   logic signed [SAMPLE_BITS-1:0] ys [FIELD_LANES];
   logic [ACT_LANES-1:0][SAMPLE_BITS-1:0]   lane_ad;
   logic [ACT_LANES-1:0][2*SAMPLE_BITS-1:0] lane_sq;

   logic [BIN_W-1:0]  run_cur, run_inc, run_next, close_bin, hist_addr;
   logic [BEXT_W-1:0] bin_ext;
   logic              bin_in_range;
   logic              is_point, is_read, is_clear, close_run;
   hist_cmd_type      hist_cmd;
   logic [CNT_W-1:0]  hist_rd;

   assign accept = start && !busy;
   assign busy   = !(state_ff == ST_IDLE || state_ff == ST_RESP);

   // ---------------------------------------------------------------
   // Configuration registers; threshold squared once at write time.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff   <= NORM_EUCLID;
         thr_ff    <= THR_W'(1);
         thr_sq_ff <= LIMIT_W'(1);
         dims_ff   <= DIMS_W'(1);
      end else if (csr_we) begin
         if (csr_index == CSR_NORM) begin
            norm_ff <= csr_wdata[NORM_W-1:0];
         end
         if (csr_index == CSR_THRESHOLD) begin
            thr_ff    <= csr_wdata;
            thr_sq_ff <= LIMIT_W'(csr_wdata) * LIMIT_W'(csr_wdata);
         end
         if (csr_index == CSR_DIMS) begin
            dims_ff <= csr_wdata[DIMS_W-1:0];
         end
      end
   end

   assign limit = (norm_ff == NORM_EUCLID) ? thr_sq_ff : LIMIT_W'(thr_ff);

   // ---------------------------------------------------------------
   // Distance lanes and merge.
   // ---------------------------------------------------------------
   assign xs[0] = req_x0;
   assign xs[1] = req_x1;
   assign xs[2] = req_x2;
   assign xs[3] = req_x3;
   assign ys[0] = req_y0;
   assign ys[1] = req_y1;
   assign ys[2] = req_y2;
   assign ys[3] = req_y3;

   for (genvar g = 0; g < ACT_LANES; g++) begin : g_lane
      rlh_lane #(
         .SAMPLE_BITS(SAMPLE_BITS)
      ) u_lane (
         .clock (clock),
         .load  (accept),
         .x_in  (xs[g]),
         .y_in  (ys[g]),
         .ad    (lane_ad[g]),
         .sq    (lane_sq[g])
      );
   end

   rlh_merge #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .NUM_LANES  (ACT_LANES)
   ) u_merge (
      .clock      (clock),
      .norm_mode  (norm_ff),
      .embed_dims (dims_ff),
      .limit      (limit),
      .ad         (lane_ad),
      .sq         (lane_sq),
      .recurrent  (recurrent)
   );

   // ---------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (!clear_busy) state_in = ST_IDLE;
         ST_IDLE:    if (accept) state_in = ST_DIFF;
         ST_DIFF:    state_in = ST_SQUARE;
         ST_SQUARE:  state_in = ST_MERGE;
         ST_MERGE:   state_in = ST_COMPARE;
         ST_COMPARE: state_in = ST_UPDATE;
         ST_UPDATE:  state_in = ST_RESP;
         ST_RESP:    state_in = accept ? ST_DIFF : ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_opcode;
         kind_ff <= req_line_kind;
         last_ff <= req_last_in_line;
         bin_ff  <= req_bin_index;
      end
   end

   // ---------------------------------------------------------------
   // Run tracking. A recurrent point extends the run (clamped to the
   // top bin); a miss closes an open run; end of line closes what is left.
   // At most one bin is touched per point.
   // ---------------------------------------------------------------
   assign is_point = op_ff == OP_COMPARE;
   assign is_read  = op_ff == OP_READ;
   assign is_clear = op_ff == OP_CLEAR;

   assign run_cur   = kind_ff ? vert_run_ff : diag_run_ff;
   assign run_inc   = (run_cur < RUN_MAX) ? run_cur + BIN_W'(1) : run_cur;
   assign close_run = is_point && (recurrent ? last_ff : (run_cur != '0));
   assign close_bin = recurrent ? run_inc : run_cur;
   assign run_next  = (recurrent && !last_ff) ? run_inc : '0;

   assign bin_ext      = BEXT_W'(bin_ff);
   assign bin_in_range = bin_ext < BEXT_W'(HIST_BINS);

   assign hist_cmd.valid = (state_ff == ST_UPDATE) &&
                           (close_run || (is_read && bin_in_range));
   assign hist_cmd.kind  = kind_ff;
   assign hist_cmd.zero  = is_read;
   assign hist_addr      = is_read ? bin_ext[BIN_W-1:0] : close_bin;

   always_ff @(posedge clock) begin
      if (reset) begin
         diag_run_ff    <= '0;
         vert_run_ff    <= '0;
         rec_total_ff   <= '0;
         point_total_ff <= '0;
      end else if (state_ff == ST_UPDATE) begin
         if (is_point) begin
            if (kind_ff) begin
               vert_run_ff <= run_next;
            end else begin
               diag_run_ff <= run_next;
               if (point_total_ff != '1) begin
                  point_total_ff <= point_total_ff + CNT_W'(1);
               end
               if (recurrent && rec_total_ff != '1) begin
                  rec_total_ff <= rec_total_ff + CNT_W'(1);
               end
            end
         end else if (is_clear) begin
            diag_run_ff    <= '0;
            vert_run_ff    <= '0;
            rec_total_ff   <= '0;
            point_total_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         rsp_rec_ff <= is_point && recurrent;
         bin_sel_ff <= is_read && bin_in_range;
      end
   end

   // ---------------------------------------------------------------
   // Histogram memory.
   // ---------------------------------------------------------------
   rlh_hist #(
      .HIST_BINS(HIST_BINS)
   ) u_hist (
      .clock      (clock),
      .reset      (reset),
      .cmd        (hist_cmd),
      .addr       (hist_addr),
      .rd_data    (hist_rd),
      .clear_busy (clear_busy)
   );

   // ---------------------------------------------------------------
   // Response transfer.
   // ---------------------------------------------------------------
   assign rsp_valid            = state_ff == ST_RESP;
   assign rsp_recurrent        = rsp_rec_ff;
   assign rsp_bin_count        = bin_sel_ff ? hist_rd : '0;
   assign rsp_recurrence_total = rec_total_ff;
   assign rsp_point_total      = point_total_ff;

   // ---------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------
   a_no_bin_access_in_sweep: assert property (@(posedge clock) disable iff (reset)
      hist_cmd.valid |-> !clear_busy)
      else $error("bin access during memory sweep");

   a_resp_follows_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_UPDATE))
      else $error("response without update step");

   a_totals_ordered: assert property (@(posedge clock) disable iff (reset)
      rec_total_ff <= point_total_ff)
      else $error("recurrence total above point total");

   a_runs_clamped: assert property (@(posedge clock) disable iff (reset)
      diag_run_ff <= RUN_MAX && vert_run_ff <= RUN_MAX)
      else $error("run length beyond top bin");

   a_count_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bin_count != '0 |-> !rsp_recurrent)
      else $error("bin count on a compare response");

endmodule

/* rtl/core/rlh_lane.sv */
// rlh_lane: one distance lane; absolute difference and its square of one
// component pair. No package dependencies.
module rlh_lane #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic signed [SAMPLE_BITS-1:0] x_in,
   input  logic signed [SAMPLE_BITS-1:0] y_in,
   output logic [SAMPLE_BITS-1:0]       ad,
   output logic [2*SAMPLE_BITS-1:0]     sq
);

   logic [SAMPLE_BITS-1:0]   x_ff, y_ff;
   logic [SAMPLE_BITS:0]     diff, neg;
   logic [SAMPLE_BITS-1:0]   ad_in, ad_ff;
   logic [2*SAMPLE_BITS-1:0] sq_ff;

   // |x - y| < 2**SAMPLE_BITS, so the magnitude fits SAMPLE_BITS bits
   assign diff  = {x_ff[SAMPLE_BITS-1], x_ff} - {y_ff[SAMPLE_BITS-1], y_ff};
   assign neg   = ~diff + {{SAMPLE_BITS{1'b0}}, 1'b1};
   assign ad_in = diff[SAMPLE_BITS] ? neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      ad_ff <= ad_in;
      sq_ff <= (2*SAMPLE_BITS)'(ad_ff) * (2*SAMPLE_BITS)'(ad_ff);
   end

   assign ad = ad_ff;
   assign sq = sq_ff;

endmodule

/* rtl/core/rlh_merge.sv */
// rlh_merge: combines the lane results under the selected norm and compares
// against the limit. Depends on rlh_pkg.
module rlh_merge #(
   parameter int SAMPLE_BITS = 16,
   parameter int NUM_LANES   = 4
) (
   input  logic                                    clock,
   input  logic [rlh_pkg::NORM_W-1:0]              norm_mode,
   input  logic [rlh_pkg::DIMS_W-1:0]              embed_dims,
   input  logic [rlh_pkg::LIMIT_W-1:0]             limit,
   input  logic [NUM_LANES-1:0][SAMPLE_BITS-1:0]   ad,
   input  logic [NUM_LANES-1:0][2*SAMPLE_BITS-1:0] sq,
   output logic                                    recurrent
);
   import rlh_pkg::*;

   localparam int DIST_W = 2 * SAMPLE_BITS + 2;
   localparam int SUM_W  = SAMPLE_BITS + 2;
   localparam int CMP_W  = DIST_W > LIMIT_W ? DIST_W : LIMIT_W;

   logic [DIMS_W-1:0]      dims_eff;
   logic [NUM_LANES-1:0]   active;
   logic [DIST_W-1:0]      sum_sq, dist_in, dist_ff;
   logic [SUM_W-1:0]       sum_ad;
   logic [SAMPLE_BITS-1:0] max_ad;
   logic                   rec_ff;

   // zero dimensions act as one, too many act as the lane count
   always_comb begin
      if (embed_dims == '0) begin
         dims_eff = DIMS_W'(1);
      end else if (embed_dims > DIMS_W'(NUM_LANES)) begin
         dims_eff = DIMS_W'(NUM_LANES);
      end else begin
         dims_eff = embed_dims;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         active[k] = DIMS_W'(k) < dims_eff;
      end
   end

   always_comb begin
      sum_sq = '0;
      sum_ad = '0;
      max_ad = '0;
      for (int k = 0; k < NUM_LANES; k++) begin
         if (active[k]) begin
            sum_sq = sum_sq + DIST_W'(sq[k]);
            sum_ad = sum_ad + SUM_W'(ad[k]);
            if (ad[k] > max_ad) begin
               max_ad = ad[k];
            end
         end
      end
   end

   always_comb begin
      unique case (norm_mode)
         NORM_EUCLID: dist_in = sum_sq;
         NORM_MAX:    dist_in = DIST_W'(max_ad);
         NORM_SUM:    dist_in = DIST_W'(sum_ad);
         default:     dist_in = DIST_W'(sum_ad);  // unused code behaves as sum
      endcase
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      rec_ff  <= CMP_W'(dist_ff) <= CMP_W'(limit);
   end

   assign recurrent = rec_ff;

endmodule

/* rtl/core/rlh_hist.sv */
// rlh_hist: diagonal and vertical line-length histograms in one memory, with
// saturating read-modify-write and a clearing sweep after reset. Depends on rlh_pkg.
module rlh_hist #(
   parameter int HIST_BINS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rlh_pkg::hist_cmd_type       cmd,
   input  logic [$clog2(HIST_BINS)-1:0] addr,
   output logic [rlh_pkg::CNT_W-1:0]   rd_data,
   output logic                        clear_busy
);
   import rlh_pkg::*;

   localparam int BIN_W = $clog2(HIST_BINS);

   logic [CNT_W-1:0] mem [0:1][0:HIST_BINS-1];

   logic             sweep_ff;
   logic             sweep_kind_ff;
   logic [BIN_W-1:0] sweep_bin_ff;
   logic             pend_ff;
   logic             pend_zero_ff;
   logic             kind_ff;
   logic [BIN_W-1:0] addr_ff;
   logic [CNT_W-1:0] rd_data_ff;
   logic [CNT_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_kind_ff <= 1'b0;
         sweep_bin_ff  <= '0;
         pend_ff       <= 1'b0;
      end else begin
         pend_ff <= cmd.valid;
         if (sweep_ff) begin
            if (sweep_bin_ff == BIN_W'(HIST_BINS - 1)) begin
               sweep_bin_ff <= '0;
               if (sweep_kind_ff) begin
                  sweep_ff <= 1'b0;
               end else begin
                  sweep_kind_ff <= 1'b1;
               end
            end else begin
               sweep_bin_ff <= sweep_bin_ff + BIN_W'(1);
            end
         end
      end
   end

   // saturating increment, or clear on a bin read
   always_comb begin
      if (pend_zero_ff) begin
         wr_data = '0;
      end else if (rd_data_ff == '1) begin
         wr_data = rd_data_ff;
      end else begin
         wr_data = rd_data_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (sweep_ff) begin
         mem[sweep_kind_ff][sweep_bin_ff] <= '0;
      end else if (pend_ff) begin
         mem[kind_ff][addr_ff] <= wr_data;
      end
      if (cmd.valid) begin
         rd_data_ff   <= mem[cmd.kind][addr];
         kind_ff      <= cmd.kind;
         addr_ff      <= addr;
         pend_zero_ff <= cmd.zero;
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = sweep_ff;

endmodule
